/* design/http2_stream_state_table_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef HTTP2_STREAM_STATE_TABLE_CORE_DEFINES_SVH
`define HTTP2_STREAM_STATE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

  // Action codes
  localparam logic [3:0] ACT_CREATE    = 4'd0;
  localparam logic [3:0] ACT_CLOSE     = 4'd1;
  localparam logic [3:0] ACT_SEND_HDR  = 4'd2;
  localparam logic [3:0] ACT_RECV_HDR  = 4'd3;
  localparam logic [3:0] ACT_SEND_DATA = 4'd4;
  localparam logic [3:0] ACT_RECV_DATA = 4'd5;
  localparam logic [3:0] ACT_SEND_RST  = 4'd6;
  localparam logic [3:0] ACT_RECV_RST  = 4'd7;
  localparam logic [3:0] ACT_USE_SEND  = 4'd8;
  localparam logic [3:0] ACT_USE_RECV  = 4'd9;
  localparam logic [3:0] ACT_ADD_ALL   = 4'd10;

  // Status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NO_STREAM = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_WINDOW    = 2'd3;

  // Stream phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_OPEN   = 3'd1;
  localparam logic [2:0] PH_HCL    = 3'd2;
  localparam logic [2:0] PH_HCR    = 3'd3;
  localparam logic [2:0] PH_CLOSED = 3'd4;

  // Config register indexes
  localparam logic CFG_INIT_WINDOW = 1'b0;
  localparam logic CFG_MAX_STREAMS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [30:0]        id;
    logic [2:0]         phase;
    logic signed [31:0] send_win;
    logic signed [31:0] recv_win;
  } entry_t;

  // Phase transition for header, data and reset events
  function automatic logic [2:0] next_phase(input logic [2:0] ph, input logic [3:0] act,
                                            input logic es);
    logic [2:0] np;
    np = ph;
    case (act)
      ACT_SEND_HDR: begin
        if (ph == PH_IDLE) np = es ? PH_HCL : PH_OPEN;
        else if (ph == PH_OPEN && es) np = PH_HCL;
        else if (ph == PH_HCR && es) np = PH_CLOSED;
      end
      ACT_RECV_HDR: begin
        if (ph == PH_IDLE) np = es ? PH_HCR : PH_OPEN;
        else if (ph == PH_OPEN && es) np = PH_HCR;
        else if (ph == PH_HCL && es) np = PH_CLOSED;
      end
      ACT_SEND_DATA: begin
        if (es && ph == PH_OPEN) np = PH_HCL;
        else if (es && ph == PH_HCR) np = PH_CLOSED;
      end
      ACT_RECV_DATA: begin
        if (es && ph == PH_OPEN) np = PH_HCR;
        else if (es && ph == PH_HCL) np = PH_CLOSED;
      end
      default: np = PH_CLOSED;
    endcase
    return np;
  endfunction

  // Signed 32-bit saturation of a 33-bit result
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/sst_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module sst_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire sst_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output sst_pkg::entry_t      rdata
);

  sst_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/http2_stream_state_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Stream table with one command in flight at a time. A command runs from start
// to its result through a scan state, a read state and an execute state:
// the id search walks every entry through the single read port of the entry
// memory, one entry a cycle, and add_all writes each updated send window back
// during that same walk; the read state then reads the addressed entry and the
// execute state applies the action and writes it back. The result appears on
// the out_ ports for exactly one cycle with out_valid high and cannot be held
// off; busy drops in that same cycle, so the next command may start while the
// result is shown.
module http2_stream_state_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_action,
  input  wire logic [30:0]        in_stream_id,
  input  wire logic               in_end_stream,
  input  wire logic signed [31:0] in_amount,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [2:0]              out_stream_state,
  output logic signed [31:0]      out_send_window_out,
  output logic signed [31:0]      out_recv_window_out,
  output logic [4:0]              out_active_count,
  output logic                    out_room_left,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [30:0]        cfg_wdata
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int ACW  = CW + 5;

  sst_pkg::state_t state_r, state_nxt;

  logic [30:0]        init_win_r;
  logic [4:0]         max_str_r;
  logic [3:0]         act_r;
  logic [30:0]        id_r;
  logic               es_r;
  logic signed [31:0] amt_r;

  logic [TABLE_DEPTH-1:0] used_r;
  logic [CW-1:0]          used_cnt_r, used_cnt_nxt;
  logic [CW-1:0]          act_cnt_r, act_cnt_nxt;

  logic [CW-1:0] cnt_r;
  logic [AW-1:0] prev_addr_r;
  logic          hit_r, free_r;
  logic [AW-1:0] hit_idx_r, free_idx_r;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  sst_pkg::entry_t mem_wdata, mem_rdata;

  logic            scan_proc;
  logic            scan_match;
  sst_pkg::entry_t scan_wdata;

  logic [1:0]         ex_status;
  logic [2:0]         ex_phase;
  logic signed [31:0] ex_sw, ex_rw;
  logic               ex_we, ex_set, ex_clr;
  logic [AW-1:0]      ex_tgt;
  sst_pkg::entry_t    ex_wdata;
  logic signed [32:0] ex_diff;
  logic [ACW-1:0]     act_ext;

  sst_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy = (state_r != sst_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sst_pkg::ST_IDLE: if (start) state_nxt = sst_pkg::ST_SCAN;
      sst_pkg::ST_SCAN: if (cnt_r == CW'(TABLE_DEPTH)) state_nxt = sst_pkg::ST_READ;
      sst_pkg::ST_READ: state_nxt = sst_pkg::ST_EXEC;
      sst_pkg::ST_EXEC: state_nxt = sst_pkg::ST_IDLE;
      default:          state_nxt = sst_pkg::ST_IDLE;
    endcase
  end

  // Scan datapath: compare the entry read last cycle, update add_all windows
  always_comb begin
    scan_proc  = (state_r == sst_pkg::ST_SCAN) && (cnt_r != '0);
    scan_match = scan_proc && used_r[prev_addr_r] && (mem_rdata.id == id_r);
    scan_wdata = mem_rdata;
    scan_wdata.send_win = sst_pkg::sat32(33'(mem_rdata.send_win) + 33'(amt_r));
  end

  // Execute the action on the addressed entry
  always_comb begin
    ex_status    = sst_pkg::STS_OK;
    ex_phase     = sst_pkg::PH_IDLE;
    ex_sw        = '0;
    ex_rw        = '0;
    ex_we        = 1'b0;
    ex_set       = 1'b0;
    ex_clr       = 1'b0;
    ex_tgt       = hit_idx_r;
    ex_wdata     = mem_rdata;
    ex_diff      = '0;
    used_cnt_nxt = used_cnt_r;
    act_cnt_nxt  = act_cnt_r;
    case (act_r)
      sst_pkg::ACT_CREATE: begin
        if (CMPW'(used_cnt_r) >= CMPW'(max_str_r) || (!hit_r && !free_r)) begin
          ex_status = sst_pkg::STS_FULL;
        end else begin
          ex_tgt            = hit_r ? hit_idx_r : free_idx_r;
          ex_we             = 1'b1;
          ex_wdata.id       = id_r;
          ex_wdata.phase    = sst_pkg::PH_IDLE;
          ex_wdata.send_win = 32'(init_win_r);
          ex_wdata.recv_win = 32'(init_win_r);
          if (!hit_r) begin
            ex_set       = 1'b1;
            used_cnt_nxt = used_cnt_r + 1'b1;
            act_cnt_nxt  = act_cnt_r + 1'b1;
          end else if (mem_rdata.phase == sst_pkg::PH_CLOSED) begin
            act_cnt_nxt = act_cnt_r + 1'b1;
          end
          ex_phase = ex_wdata.phase;
          ex_sw    = ex_wdata.send_win;
          ex_rw    = ex_wdata.recv_win;
        end
      end
      sst_pkg::ACT_ADD_ALL: begin
        if (hit_r) begin
          ex_phase = mem_rdata.phase;
          ex_sw    = mem_rdata.send_win;
          ex_rw    = mem_rdata.recv_win;
        end
      end
      default: begin
        if (!hit_r) begin
          ex_status = sst_pkg::STS_NO_STREAM;
        end else begin
          if (act_r == sst_pkg::ACT_CLOSE) begin
            ex_we          = 1'b1;
            ex_clr         = 1'b1;
            ex_wdata.phase = sst_pkg::PH_CLOSED;
            used_cnt_nxt   = used_cnt_r - 1'b1;
            if (mem_rdata.phase != sst_pkg::PH_CLOSED) act_cnt_nxt = act_cnt_r - 1'b1;
          end else if (act_r inside {[sst_pkg::ACT_SEND_HDR : sst_pkg::ACT_RECV_RST]}) begin
            ex_we          = 1'b1;
            ex_wdata.phase = sst_pkg::next_phase(mem_rdata.phase, act_r, es_r);
            if (mem_rdata.phase != sst_pkg::PH_CLOSED &&
                ex_wdata.phase == sst_pkg::PH_CLOSED) act_cnt_nxt = act_cnt_r - 1'b1;
          end else if (act_r == sst_pkg::ACT_USE_SEND) begin
            ex_diff = 33'(mem_rdata.send_win) - 33'(amt_r);
            if (mem_rdata.send_win < amt_r) ex_status = sst_pkg::STS_WINDOW;
            else begin
              ex_we             = 1'b1;
              ex_wdata.send_win = sst_pkg::sat32(ex_diff);
            end
          end else if (act_r == sst_pkg::ACT_USE_RECV) begin
            ex_diff = 33'(mem_rdata.recv_win) - 33'(amt_r);
            if (mem_rdata.recv_win < amt_r) ex_status = sst_pkg::STS_WINDOW;
            else begin
              ex_we             = 1'b1;
              ex_wdata.recv_win = sst_pkg::sat32(ex_diff);
            end
          end
          ex_phase = ex_wdata.phase;
          ex_sw    = ex_wdata.send_win;
          ex_rw    = ex_wdata.recv_win;
        end
      end
    endcase
    act_ext = ACW'(act_cnt_nxt);
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = prev_addr_r;
    mem_wdata = scan_wdata;
    mem_raddr = cnt_r[AW-1:0];
    case (state_r)
      sst_pkg::ST_SCAN: begin
        mem_we = scan_proc && used_r[prev_addr_r] && (act_r == sst_pkg::ACT_ADD_ALL);
      end
      sst_pkg::ST_READ: begin
        mem_raddr = (act_r == sst_pkg::ACT_CREATE && !hit_r) ? free_idx_r : hit_idx_r;
      end
      sst_pkg::ST_EXEC: begin
        mem_we    = ex_we;
        mem_waddr = ex_tgt;
        mem_wdata = ex_wdata;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sst_pkg::ST_IDLE;
      init_win_r <= 31'd65535;
      max_str_r  <= 5'd16;
      used_r     <= '0;
      used_cnt_r <= '0;
      act_cnt_r  <= '0;
      out_valid  <= 1'b0;
      cnt_r      <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == sst_pkg::ST_EXEC);
      // Take config writes
      if (cfg_we) begin
        if (cfg_index == sst_pkg::CFG_INIT_WINDOW) init_win_r <= cfg_wdata;
        else max_str_r <= cfg_wdata[4:0];
      end
      if (state_r == sst_pkg::ST_IDLE) begin
        cnt_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end
      // Advance the walk and record first hit and first free entry
      if (state_r == sst_pkg::ST_SCAN) begin
        if (cnt_r != CW'(TABLE_DEPTH)) cnt_r <= cnt_r + 1'b1;
        if (scan_match && !hit_r) hit_r <= 1'b1;
        if (scan_proc && !used_r[prev_addr_r] && !free_r) free_r <= 1'b1;
      end
      // Commit the action
      if (state_r == sst_pkg::ST_EXEC) begin
        used_cnt_r <= used_cnt_nxt;
        act_cnt_r  <= act_cnt_nxt;
        if (ex_set) used_r[ex_tgt] <= 1'b1;
        if (ex_clr) used_r[ex_tgt] <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == sst_pkg::ST_IDLE && start) begin
      act_r <= in_action;
      id_r  <= in_stream_id;
      es_r  <= in_end_stream;
      amt_r <= in_amount;
    end
    prev_addr_r <= cnt_r[AW-1:0];
    if (scan_match && !hit_r) hit_idx_r <= prev_addr_r;
    if (scan_proc && !used_r[prev_addr_r] && !free_r) free_idx_r <= prev_addr_r;
    if (state_r == sst_pkg::ST_EXEC) begin
      out_status          <= ex_status;
      out_stream_state    <= ex_phase;
      out_send_window_out <= ex_sw;
      out_recv_window_out <= ex_rw;
      out_active_count    <= act_ext[4:0];
      out_room_left       <= (CMPW'(used_cnt_nxt) < CMPW'(max_str_r)) &&
                             (CMPW'(used_cnt_nxt) < CMPW'(TABLE_DEPTH));
    end
  end

endmodule
`default_nettype wire

/* design/sst_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "http2_stream_state_table_core_defines.svh"
module sst_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [1:0]         out_status,
  input wire logic [2:0]         out_stream_state,
  input wire logic signed [31:0] out_send_window_out,
  input wire logic signed [31:0] out_recv_window_out
);

  // A result closes the transaction and frees the block
  `SST_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while busy")
  // An accepted transaction makes the block busy
  `SST_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start did not raise busy")
  // One result per transaction, never two in a row
  `SST_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "back-to-back result strobes")
  // Missing stream reports an empty entry
  `SST_ASSERT_NOW(a_missing_empty, out_valid && out_status == sst_pkg::STS_NO_STREAM,
    out_stream_state == sst_pkg::PH_IDLE && out_send_window_out == 32'sd0 &&
    out_recv_window_out == 32'sd0, "missing stream reported nonzero fields")

endmodule

bind http2_stream_state_table_core sst_chk u_sst_chk (.*);
`default_nettype wire
